[hw/rtl/cpsg_pkg.sv]
// Shared constants, types and coordinate helpers for the circle point and span generator.
package cpsg_pkg;

  localparam int COORD_BITS    = 12;
  localparam int IN_COORD_BITS = 12;
  localparam int OUT_BITS      = 14;
  localparam int COLOR_BITS    = 8;
  localparam int DEC_BITS      = COORD_BITS + 5;
  localparam int NXT_BITS      = COORD_BITS + 2;
  localparam int QUEUE_DEPTH   = 2;
  localparam int PTR_BITS      = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS      = $clog2(QUEUE_DEPTH + 1);
  localparam int STEP_BITS     = 3;

  localparam logic [STEP_BITS-1:0] OUTLINE_LAST = STEP_BITS'(7);
  localparam logic [STEP_BITS-1:0] FILL_LAST    = STEP_BITS'(3);

  localparam int INIT_BIAS = 3;
  localparam int NEG_BIAS  = 6;
  localparam int POS_BIAS  = 10;

  typedef enum logic {
    FUNC_START   = 1'b0,
    FUNC_ADVANCE = 1'b1
  } func_t;

  // One iteration's worth of work, handed from front to back.
  typedef struct packed {
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [COORD_BITS-1:0] xo;
    logic [COORD_BITS-1:0] yo;
    logic                  fill;
    logic [COLOR_BITS-1:0] color;
    logic                  done;
  } group_t;

  // c +/- o, wrapped to the output width.
  function automatic logic [OUT_BITS-1:0] offset_coord(
    input logic [COORD_BITS-1:0] c,
    input logic [COORD_BITS-1:0] o,
    input logic                  neg
  );
    logic [31:0] s;
    s = neg ? (32'(c) - 32'(o)) : (32'(c) + 32'(o));
    return s[OUT_BITS-1:0];
  endfunction

endpackage

[hw/rtl/cpsg_front.sv]
// Front end: takes requests, holds circle state, runs the decision update per advance.
module cpsg_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  input  logic                                 func,
  input  logic [cpsg_pkg::IN_COORD_BITS-1:0]   center_x,
  input  logic [cpsg_pkg::IN_COORD_BITS-1:0]   center_y,
  input  logic [cpsg_pkg::IN_COORD_BITS-1:0]   radius,
  input  logic                                 fill,
  input  logic [cpsg_pkg::COLOR_BITS-1:0]      color,
  output logic                                 grp_push,
  output cpsg_pkg::group_t                     grp
);

  logic [cpsg_pkg::COORD_BITS-1:0]   centre_col;
  logic [cpsg_pkg::COORD_BITS-1:0]   centre_row;
  logic [cpsg_pkg::COORD_BITS-1:0]   x_offset;
  logic [cpsg_pkg::COORD_BITS-1:0]   y_offset;
  logic signed [cpsg_pkg::DEC_BITS-1:0] decision;
  logic                              fill_mode;
  logic [cpsg_pkg::COLOR_BITS-1:0]   draw_color;
  logic                              active;

  logic                              is_start;
  logic [cpsg_pkg::COORD_BITS-1:0]   r_in;
  logic signed [cpsg_pkg::DEC_BITS-1:0] dec_init;
  logic signed [cpsg_pkg::DEC_BITS-1:0] decision_next;
  logic signed [cpsg_pkg::DEC_BITS-1:0] xo4;
  logic signed [cpsg_pkg::DEC_BITS-1:0] yo4;
  logic                              step_y;
  logic signed [cpsg_pkg::NXT_BITS-1:0] xo_next;
  logic signed [cpsg_pkg::NXT_BITS-1:0] yo_next;
  logic                              done;

  assign is_start = (func == cpsg_pkg::FUNC_START);
  assign r_in     = cpsg_pkg::COORD_BITS'(radius);
  assign dec_init = $signed(cpsg_pkg::DEC_BITS'(cpsg_pkg::INIT_BIAS))
                  - $signed(cpsg_pkg::DEC_BITS'({r_in, 1'b0}));

  assign xo4    = $signed(cpsg_pkg::DEC_BITS'({x_offset, 2'b00}));
  assign yo4    = $signed(cpsg_pkg::DEC_BITS'({y_offset, 2'b00}));
  assign step_y = !decision[cpsg_pkg::DEC_BITS-1];

  always_comb begin
    if (step_y) begin
      decision_next = decision + xo4 - yo4
                    + $signed(cpsg_pkg::DEC_BITS'(cpsg_pkg::POS_BIAS));
    end else begin
      decision_next = decision + xo4
                    + $signed(cpsg_pkg::DEC_BITS'(cpsg_pkg::NEG_BIAS));
    end
  end

  // Offsets after this iteration; y can dip below zero only on the final group.
  assign xo_next = $signed(cpsg_pkg::NXT_BITS'(x_offset)) + $signed(cpsg_pkg::NXT_BITS'(1));
  assign yo_next = $signed(cpsg_pkg::NXT_BITS'(y_offset))
                 - $signed(cpsg_pkg::NXT_BITS'(step_y));
  assign done    = (yo_next < xo_next);

  assign grp_push   = req_valid && !is_start && active;
  assign grp.cx     = centre_col;
  assign grp.cy     = centre_row;
  assign grp.xo     = x_offset;
  assign grp.yo     = y_offset;
  assign grp.fill   = fill_mode;
  assign grp.color  = draw_color;
  assign grp.done   = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_col <= '0;
      centre_row <= '0;
      x_offset   <= '0;
      y_offset   <= '0;
      decision   <= '0;
      fill_mode  <= 1'b0;
      draw_color <= '0;
      active     <= 1'b0;
    end else if (req_valid && is_start) begin
      centre_col <= cpsg_pkg::COORD_BITS'(center_x);
      centre_row <= cpsg_pkg::COORD_BITS'(center_y);
      x_offset   <= '0;
      y_offset   <= r_in;
      decision   <= dec_init;
      fill_mode  <= fill;
      draw_color <= color;
      active     <= 1'b1;
    end else if (grp_push) begin
      x_offset   <= xo_next[cpsg_pkg::COORD_BITS-1:0];
      y_offset   <= yo_next[cpsg_pkg::COORD_BITS-1:0];
      decision   <= decision_next;
      active     <= !done;
    end
  end

endmodule

[hw/rtl/cpsg_queue.sv]
// Short queue of iteration groups between front and back.
module cpsg_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  cpsg_pkg::group_t  wr_data,
  output logic              q_full,
  input  logic              rd_en,
  output logic              rd_valid,
  output cpsg_pkg::group_t  rd_data
);

  cpsg_pkg::group_t                 slots [cpsg_pkg::QUEUE_DEPTH];
  logic [cpsg_pkg::PTR_BITS-1:0]    wr_ptr;
  logic [cpsg_pkg::PTR_BITS-1:0]    rd_ptr;
  logic [cpsg_pkg::CNT_BITS-1:0]    count;
  logic                             do_wr;
  logic                             do_rd;

  assign q_full   = (count == cpsg_pkg::CNT_BITS'(cpsg_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/cpsg_back.sv]
// Back end: walks a queued group into points or spans, one per cycle while the result register has room.
module cpsg_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_valid,
  input  cpsg_pkg::group_t                      g,
  output logic                                  q_pop,
  input  logic                                  res_pop,
  output logic                                  res_valid,
  output logic signed [cpsg_pkg::OUT_BITS-1:0]  px,
  output logic signed [cpsg_pkg::OUT_BITS-1:0]  py,
  output logic signed [cpsg_pkg::OUT_BITS-1:0]  px_end,
  output logic [cpsg_pkg::COLOR_BITS-1:0]       pixel_color,
  output logic                                  group_last,
  output logic                                  circle_done
);

  logic [cpsg_pkg::STEP_BITS-1:0] idx;
  logic                           room;
  logic                           step;
  logic                           last;
  logic                           swap;
  logic [cpsg_pkg::COORD_BITS-1:0] a_off;
  logic [cpsg_pkg::COORD_BITS-1:0] b_off;
  logic                           col_neg;
  logic                           row_neg;
  logic [cpsg_pkg::OUT_BITS-1:0]  col_a;
  logic [cpsg_pkg::OUT_BITS-1:0]  col_b;
  logic [cpsg_pkg::OUT_BITS-1:0]  row_v;

  assign room = !res_valid || res_pop;
  assign step = q_valid && room;
  assign last = g.fill ? (idx == cpsg_pkg::FILL_LAST) : (idx == cpsg_pkg::OUTLINE_LAST);
  assign q_pop = step && last;

  // Outline groups swap the roles of the two offsets in their second half, fill groups on every odd span.
  assign swap    = g.fill ? idx[0] : idx[2];
  assign a_off   = swap ? g.yo : g.xo;
  assign b_off   = swap ? g.xo : g.yo;
  assign col_neg = g.fill ? 1'b1 : (idx[0] ^ idx[1]);
  assign row_neg = idx[1];

  assign col_a = cpsg_pkg::offset_coord(g.cx, a_off, col_neg);
  assign col_b = cpsg_pkg::offset_coord(g.cx, a_off, 1'b0);
  assign row_v = cpsg_pkg::offset_coord(g.cy, b_off, row_neg);

  always_ff @(posedge clk) begin
    if (step) begin
      px          <= $signed(col_a);
      py          <= $signed(row_v);
      px_end      <= g.fill ? $signed(col_b) : $signed(col_a);
      pixel_color <= g.color;
      group_last  <= last;
      circle_done <= g.done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (step) begin
        idx       <= last ? '0 : idx + 1'b1;
        res_valid <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_fill_idx: assert property (@(posedge clk) disable iff (rst)
    q_valid && g.fill |-> idx <= cpsg_pkg::FILL_LAST)
    else $error("span index past last span");

  a_idx_needs_group: assert property (@(posedge clk) disable iff (rst)
    idx != '0 |-> q_valid)
    else $error("group left the queue before all results were made");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result register valid after reset");
`endif

endmodule

[hw/rtl/circle_point_and_span_generator.sv]
// Top level of the midpoint circle point and span generator.
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------------
//  request  | push in, full out   | func, center_x, center_y, radius, fill, color
//  result   | pop in, empty out   | px, py, px_end, pixel_color, group_last,
//           |                     | circle_done
//
// A start request gives no result. An advance request on an active circle
// queues one group; the back turns it into results, 8 for an outline group
// and 4 for a fill group, through the single result register that it
// fills. Sustained rate is one result per cycle while results are popped.
// Reset (rst, synchronous) drops any circle in progress and empties both
// the group queue and the result register. full rises only while the
// group queue holds its two groups; the front keeps the decision update
// going independently of result stalls until then.
module circle_point_and_span_generator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  func,
  input  logic [cpsg_pkg::IN_COORD_BITS-1:0]    center_x,
  input  logic [cpsg_pkg::IN_COORD_BITS-1:0]    center_y,
  input  logic [cpsg_pkg::IN_COORD_BITS-1:0]    radius,
  input  logic                                  fill,
  input  logic [cpsg_pkg::COLOR_BITS-1:0]       color,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [cpsg_pkg::OUT_BITS-1:0]  px,
  output logic signed [cpsg_pkg::OUT_BITS-1:0]  py,
  output logic signed [cpsg_pkg::OUT_BITS-1:0]  px_end,
  output logic [cpsg_pkg::COLOR_BITS-1:0]       pixel_color,
  output logic                                  group_last,
  output logic                                  circle_done
);

  logic             req_valid;
  logic             grp_push;
  cpsg_pkg::group_t grp_in;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  cpsg_pkg::group_t grp_head;
  logic             res_valid;

  // Any request stalls while the queue is full; start requests included,
  // so circle state never changes under a group that has not been queued.
  assign full      = q_full;
  assign req_valid = push && !q_full;
  assign empty     = !res_valid;

  cpsg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .func      (func),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius    (radius),
    .fill      (fill),
    .color     (color),
    .grp_push  (grp_push),
    .grp       (grp_in)
  );

  cpsg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (grp_push),
    .wr_data  (grp_in),
    .q_full   (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (grp_head)
  );

  cpsg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .g           (grp_head),
    .q_pop       (q_pop),
    .res_pop     (pop),
    .res_valid   (res_valid),
    .px          (px),
    .py          (py),
    .px_end      (px_end),
    .pixel_color (pixel_color),
    .group_last  (group_last),
    .circle_done (circle_done)
  );

endmodule

[tb/cpsg_pixel_check.sv]
// Watches both channels of the circle generator, predicts its pixels and spans, and compares.
module cpsg_pixel_check
  import cpsg_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  logic                        full,
  input  logic                        func,
  input  logic [IN_COORD_BITS-1:0]    center_x,
  input  logic [IN_COORD_BITS-1:0]    center_y,
  input  logic [IN_COORD_BITS-1:0]    radius,
  input  logic                        fill,
  input  logic [COLOR_BITS-1:0]       color,
  input  logic                        empty,
  input  logic                        pop,
  input  logic signed [OUT_BITS-1:0]  px,
  input  logic signed [OUT_BITS-1:0]  py,
  input  logic signed [OUT_BITS-1:0]  px_end,
  input  logic [COLOR_BITS-1:0]       pixel_color,
  input  logic                        group_last,
  input  logic                        circle_done,
  output int unsigned                 fail_count,
  output int unsigned                 pending
);

  typedef struct packed {
    logic [OUT_BITS-1:0]   col;
    logic [OUT_BITS-1:0]   row;
    logic [OUT_BITS-1:0]   col_end;
    logic [COLOR_BITS-1:0] ink;
    logic                  last;
    logic                  done;
  } pixel_t;

  pixel_t                pixel_q[$];
  logic [COORD_BITS-1:0] ctr_col;
  logic [COORD_BITS-1:0] ctr_row;
  int                    xo;
  int                    yo;
  longint                dec;
  logic                  fill_on;
  logic [COLOR_BITS-1:0] ink;
  bit                    running;

  function automatic pixel_t make_pixel(int a, int row, int b);
    pixel_t p;
    logic [31:0] ta, tr, tb;
    ta = a;
    tr = row;
    tb = b;
    p.col     = ta[OUT_BITS-1:0];
    p.row     = tr[OUT_BITS-1:0];
    p.col_end = tb[OUT_BITS-1:0];
    p.ink     = ink;
    p.last    = 1'b0;
    p.done    = 1'b0;
    return p;
  endfunction

  // One midpoint iteration: queue its group, then step the decision value.
  task automatic plot_iteration();
    pixel_t grp[8];
    int     cx;
    int     cy;
    int     n;
    bit     fin;
    cx = ctr_col;
    cy = ctr_row;
    if (fill_on) begin
      grp[0] = make_pixel(cx - xo, cy + yo, cx + xo);
      grp[1] = make_pixel(cx - yo, cy + xo, cx + yo);
      grp[2] = make_pixel(cx - xo, cy - yo, cx + xo);
      grp[3] = make_pixel(cx - yo, cy - xo, cx + yo);
      n = 4;
    end else begin
      grp[0] = make_pixel(cx + xo, cy + yo, cx + xo);
      grp[1] = make_pixel(cx - xo, cy + yo, cx - xo);
      grp[2] = make_pixel(cx - xo, cy - yo, cx - xo);
      grp[3] = make_pixel(cx + xo, cy - yo, cx + xo);
      grp[4] = make_pixel(cx + yo, cy + xo, cx + yo);
      grp[5] = make_pixel(cx - yo, cy + xo, cx - yo);
      grp[6] = make_pixel(cx - yo, cy - xo, cx - yo);
      grp[7] = make_pixel(cx + yo, cy - xo, cx + yo);
      n = 8;
    end
    if (dec < 0) begin
      dec += 4 * xo + NEG_BIAS;
    end else begin
      dec += 4 * (xo - yo) + POS_BIAS;
      yo--;
    end
    xo++;
    fin = (yo < xo);
    if (fin) running = 1'b0;
    grp[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) begin
      grp[k].done = fin;
      pixel_q.push_back(grp[k]);
    end
  endtask

  task automatic flag(string field, int want, int got);
    fail_count++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endtask

  task automatic compare_pixel();
    pixel_t want;
    if (pixel_q.size() == 0) begin
      fail_count++;
      $error("result popped with nothing expected");
    end else begin
      want = pixel_q.pop_front();
      if (px !== want.col)             flag("px", want.col, px);
      if (py !== want.row)             flag("py", want.row, py);
      if (px_end !== want.col_end)     flag("px_end", want.col_end, px_end);
      if (pixel_color !== want.ink)    flag("pixel_color", want.ink, pixel_color);
      if (group_last !== want.last)    flag("group_last", want.last, group_last);
      if (circle_done !== want.done)   flag("circle_done", want.done, circle_done);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pixel_q.delete();
      ctr_col    = '0;
      ctr_row    = '0;
      xo         = 0;
      yo         = 0;
      dec        = 0;
      fill_on    = 1'b0;
      ink        = '0;
      running    = 1'b0;
      fail_count = 0;
    end else begin
      if (push && !full) begin
        if (func == FUNC_START) begin
          ctr_col = center_x[COORD_BITS-1:0];
          ctr_row = center_y[COORD_BITS-1:0];
          xo      = 0;
          yo      = radius[COORD_BITS-1:0];
          dec     = INIT_BIAS - 2 * longint'(yo);
          fill_on = fill;
          ink     = color;
          running = 1'b1;
        end else if (running && yo >= xo) begin
          plot_iteration();
        end
      end
      if (pop && !empty) compare_pixel();
    end
    pending <= pixel_q.size();
  end

endmodule

[tb/circle_point_and_span_generator_tb.sv]
// Top of the circle generator testbench: clock, reset, request and pop stimulus, verdict.
module circle_point_and_span_generator_tb;
  import cpsg_pkg::*;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        push = 1'b0;
  logic                        full;
  logic                        func = FUNC_START;
  logic [IN_COORD_BITS-1:0]    center_x = '0;
  logic [IN_COORD_BITS-1:0]    center_y = '0;
  logic [IN_COORD_BITS-1:0]    radius = '0;
  logic                        fill = 1'b0;
  logic [COLOR_BITS-1:0]       color = '0;
  logic                        empty;
  logic                        pop = 1'b0;
  logic signed [OUT_BITS-1:0]  px;
  logic signed [OUT_BITS-1:0]  py;
  logic signed [OUT_BITS-1:0]  px_end;
  logic [COLOR_BITS-1:0]       pixel_color;
  logic                        group_last;
  logic                        circle_done;

  int unsigned fail_count;
  int unsigned pending;       // results predicted but not yet popped

  // Idle controls: request gaps and pop stalls are switched per circle;
  // both go off for the closing stretch of the run.
  bit send_gaps = 1'b0;
  bit pop_gaps  = 1'b0;
  int items_sent = 0;         // requests accepted so far, all kinds

  always #5 clk = ~clk;

  circle_point_and_span_generator u_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .func        (func),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius      (radius),
    .fill        (fill),
    .color       (color),
    .empty       (empty),
    .pop         (pop),
    .px          (px),
    .py          (py),
    .px_end      (px_end),
    .pixel_color (pixel_color),
    .group_last  (group_last),
    .circle_done (circle_done)
  );

  cpsg_pixel_check u_check (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .func        (func),
    .center_x    (center_x),
    .center_y    (center_y),
    .radius      (radius),
    .fill        (fill),
    .color       (color),
    .empty       (empty),
    .pop         (pop),
    .px          (px),
    .py          (py),
    .px_end      (px_end),
    .pixel_color (pixel_color),
    .group_last  (group_last),
    .circle_done (circle_done),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // Number of groups a radius yields, so a sequence knows when its circle
  // is finished and further advances would only be ignored.
  function automatic int circle_iterations(int r);
    int     x;
    int     y;
    int     n;
    longint d;
    x = 0;
    y = r;
    n = 0;
    d = INIT_BIAS - 2 * longint'(r);
    while (y >= x) begin
      n++;
      if (d < 0) begin
        d += 4 * x + NEG_BIAS;
      end else begin
        d += 4 * (x - y) + POS_BIAS;
        y--;
      end
      x++;
    end
    return n;
  endfunction

  // Present one request and hold it until the block takes it. push stays
  // high on return, so back-to-back requests need no extra edge.
  task automatic send_req(input logic f, input logic [IN_COORD_BITS-1:0] cx,
                          input logic [IN_COORD_BITS-1:0] cy,
                          input logic [IN_COORD_BITS-1:0] r,
                          input logic fl, input logic [COLOR_BITS-1:0] c);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    push     <= 1'b1;
    func     <= f;
    center_x <= cx;
    center_y <= cy;
    radius   <= r;
    fill     <= fl;
    color    <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
  endtask

  // Advance requests carry random junk in the start-only fields.
  task automatic advance_n(int n);
    repeat (n) send_req(FUNC_ADVANCE, IN_COORD_BITS'($urandom), IN_COORD_BITS'($urandom),
                        IN_COORD_BITS'($urandom), 1'($urandom), COLOR_BITS'($urandom));
  endtask

  // Hold off new requests until every predicted result has been popped.
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Pop side: random stall bursts while pop_gaps is set.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!pop_gaps) begin
        hold = 0;
        pop <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        pop <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 16) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("circle_point_and_span_generator_tb NOT OK");
    $finish;
  end

  initial begin
    int r;
    int steps;
    int k;
    bit drained_mid;
    drained_mid = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    // Advance with no circle loaded: ignored.
    advance_n(1);

    // Zero radius at the origin, outline, darkest color: one final group
    // at the centre; the trailing advance hits a finished circle.
    send_req(FUNC_START, 12'd0, 12'd0, 12'd0, 1'b0, 8'h00);
    advance_n(2);

    // Zero radius at the far corner, fill, brightest color.
    send_req(FUNC_START, 12'hFFF, 12'hFFF, 12'd0, 1'b1, 8'hFF);
    advance_n(1);

    // Largest radius at the origin: coordinates wrap negative. The circle
    // is abandoned by a new start while still active.
    pop_gaps  = 1'b1;
    send_gaps = 1'b1;
    send_req(FUNC_START, 12'd0, 12'd0, 12'hFFF, 1'b0, 8'hA5);
    advance_n(3);
    // Largest radius at the far corner, fill: spans reach the top of range.
    send_req(FUNC_START, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 8'h5A);
    advance_n(3);

    // Small circles run to completion, both modes.
    send_req(FUNC_START, 12'd100, 12'd200, 12'd1, 1'b0, 8'h3C);
    advance_n(circle_iterations(1));
    send_req(FUNC_START, 12'd7, 12'd3000, 12'd2, 1'b1, 8'hC3);
    advance_n(circle_iterations(2));
    send_req(FUNC_START, 12'd2048, 12'd2, 12'd3, 1'b0, 8'h81);
    advance_n(circle_iterations(3));

    // Pressure: let the result side empty completely before going on.
    drain_results();

    // ---- random part ----
    // Mostly well-formed circles with random content; some are cut short
    // by a new start, some get extra advances past the end, and a few use
    // a radius of any size, abandoned after a handful of groups.
    while (items_sent < 110) begin
      if (items_sent >= 90) begin
        send_gaps = 1'b0;
        pop_gaps  = 1'b0;
      end else begin
        send_gaps = ($urandom_range(0, 3) != 0);
        pop_gaps  = ($urandom_range(0, 3) != 0);
      end

      if ($urandom_range(0, 4) == 0) r = $urandom_range(0, 4095);
      else r = $urandom_range(0, 12);
      steps = circle_iterations(r);

      if (steps > 12) begin
        k = $urandom_range(1, 4);
      end else begin
        case ($urandom_range(0, 9))
          0:       k = $urandom_range(0, steps);
          1:       k = steps + $urandom_range(1, 2);
          default: k = steps;
        endcase
      end

      send_req(FUNC_START, IN_COORD_BITS'($urandom_range(0, 4095)),
               IN_COORD_BITS'($urandom_range(0, 4095)), IN_COORD_BITS'(r),
               1'($urandom_range(0, 1)), COLOR_BITS'($urandom_range(0, 255)));
      advance_n(k);

      if (!drained_mid && items_sent >= 55) begin
        drained_mid = 1'b1;
        drain_results();
      end
    end

    // ---- wind down ----
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("circle_point_and_span_generator_tb OK");
    end else begin
      $display("circle_point_and_span_generator_tb NOT OK");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/cpsg_pkg.sv
hw/rtl/cpsg_front.sv
hw/rtl/cpsg_queue.sv
hw/rtl/cpsg_back.sv
hw/rtl/circle_point_and_span_generator.sv
tb/cpsg_pixel_check.sv
tb/circle_point_and_span_generator_tb.sv
